>>> hdl/mandelbrot_escape_time_assert.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape-time assertion macros
// Clocked property checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

`ifndef SYNTHESIS

// check a property while out of reset
`define MBE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check a property on every edge, reset included
`define MBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MBE_ASSERT(lbl, clk, rstn, prop, msg)
`define MBE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> hdl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and helpers of the escape-time iterator.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int FRAC_BITS_DEF   = 28;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int Z_W             = 32;
  localparam int CNT_PORT_W      = 16;
  localparam int MAX_ITER_RESET  = 256;

  localparam int        PADDR_W      = 3;
  localparam logic      REG_MAX_ITER = 1'b0;

  // counter width actually used: the register field is 16 bits wide
  function automatic int cnt_w(input int cw);
    return (cw < CNT_PORT_W) ? cw : CNT_PORT_W;
  endfunction

  typedef struct packed {
    logic signed [Z_W-1:0] c_re;
    logic signed [Z_W-1:0] c_im;
    logic signed [Z_W-1:0] start_re;
    logic signed [Z_W-1:0] start_im;
  } in_t;

  typedef struct packed {
    logic [CNT_PORT_W-1:0] iteration_count;
    logic                  escaped;
    logic signed [Z_W-1:0] final_re;
    logic signed [Z_W-1:0] final_im;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic eval;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic max_zero;
    logic first;
    logic escape;
    logic last;
  } status_t;

endpackage

>>> hdl/mbe_regs.sv
// ----------------------------------------------------------------------------
// mbe_regs
// APB register file holding the iteration bound.
// ----------------------------------------------------------------------------
module mbe_regs
  import mbe_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [cnt_w(COUNT_WIDTH)-1:0] max_iter
);

  localparam int CNT_W = cnt_w(COUNT_WIDTH);

  logic [CNT_W-1:0] max_iter_r;
  logic             wr_en;
  logic             hit;

  assign hit    = (paddr[PADDR_W-1] == REG_MAX_ITER);
  assign wr_en  = psel && penable && pwrite && hit;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= CNT_W'(MAX_ITER_RESET);
    end else if (wr_en) begin
      // drop the bits above the counter width
      max_iter_r <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = 32'(max_iter_r);
    end
  end

  assign max_iter = max_iter_r;

endmodule

>>> hdl/mbe_ctrl.sv
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: load, then alternate multiply and update until a stop.
// ----------------------------------------------------------------------------
module mbe_ctrl
  import mbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t sts,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = sts.max_zero ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (!sts.first && (sts.escape || sts.last)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> hdl/mbe_dp.sv
// ----------------------------------------------------------------------------
// mbe_dp
// Datapath: three 32x32 products, update with floor shift and saturation,
// magnitude test, iteration counter and result register.
// ----------------------------------------------------------------------------
module mbe_dp
  import mbe_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  input  in_t                           in_data,
  input  logic [cnt_w(COUNT_WIDTH)-1:0] max_iter,
  output status_t                       sts,
  output logic                          out_valid,
  output out_t                          out_data
);

  localparam int CNT_W  = cnt_w(COUNT_WIDTH);
  localparam int P_W    = 2 * Z_W;
  localparam int TBITS  = 2 * FRAC_BITS + 2;
  localparam bit ESC_EN = (TBITS < P_W);
  localparam logic [P_W:0] THRESH = ESC_EN ? ((P_W+1)'(1) << TBITS) : '0;

  logic signed [Z_W-1:0] c_re_r, c_im_r, z_re_r, z_im_r;
  logic signed [P_W-1:0] p_rr_r, p_ii_r, p_ri_r;
  logic [CNT_W-1:0]      count_r;
  logic                  first_r;
  logic                  esc_r;
  logic                  out_valid_r;
  out_t                  out_data_r;

  logic signed [P_W:0]   diff;
  logic signed [P_W:0]   re_sh;
  logic signed [P_W+1:0] re_sum;
  logic signed [P_W-1:0] im_sh;
  logic signed [P_W:0]   im_sum;
  logic signed [Z_W-1:0] re_new, im_new;
  logic [P_W:0]          mag;
  logic                  escape;
  logic                  last;
  logic                  stop;

  // clamp a wide sum into the 32-bit signed range
  function automatic logic signed [Z_W-1:0] sat_re(input logic signed [P_W+1:0] v);
    logic ovf;
    ovf = !((&v[P_W+1:Z_W-1]) || !(|v[P_W+1:Z_W-1]));
    if (!ovf) return v[Z_W-1:0];
    return v[P_W+1] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};
  endfunction

  function automatic logic signed [Z_W-1:0] sat_im(input logic signed [P_W:0] v);
    logic ovf;
    ovf = !((&v[P_W:Z_W-1]) || !(|v[P_W:Z_W-1]));
    if (!ovf) return v[Z_W-1:0];
    return v[P_W] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};
  endfunction

  always_comb begin
    diff   = (P_W+1)'(p_rr_r) - (P_W+1)'(p_ii_r);
    re_sh  = diff >>> FRAC_BITS;
    re_sum = (P_W+2)'(re_sh) + (P_W+2)'(c_re_r);
    im_sh  = p_ri_r >>> (FRAC_BITS - 1);
    im_sum = (P_W+1)'(im_sh) + (P_W+1)'(c_im_r);
    re_new = sat_re(re_sum);
    im_new = sat_im(im_sum);
    // squares are never negative
    mag    = {1'b0, p_rr_r} + {1'b0, p_ii_r};
    escape = ESC_EN && (mag > THRESH);
    last   = ((CNT_W+1)'(count_r) + (CNT_W+1)'(1)) == (CNT_W+1)'(max_iter);
    stop   = !first_r && (escape || last);
  end

  assign sts.max_zero = (max_iter == '0);
  assign sts.first    = first_r;
  assign sts.escape   = escape;
  assign sts.last     = last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_re_r  <= in_data.c_re;
      c_im_r  <= in_data.c_im;
      z_re_r  <= in_data.start_re;
      z_im_r  <= in_data.start_im;
      count_r <= '0;
      first_r <= 1'b1;
      esc_r   <= 1'b0;
    end
    if (cmd.mul) begin
      p_rr_r <= z_re_r * z_re_r;
      p_ii_r <= z_im_r * z_im_r;
      p_ri_r <= z_re_r * z_im_r;
    end
    if (cmd.eval) begin
      first_r <= 1'b0;
      if (!first_r) begin
        // test the z that the previous update produced
        if (escape) begin
          esc_r <= 1'b1;
        end else begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (!stop) begin
        z_re_r <= re_new;
        z_im_r <= im_new;
      end
    end
    if (cmd.emit) begin
      out_data_r.iteration_count <= CNT_PORT_W'(count_r);
      out_data_r.escaped         <= esc_r;
      out_data_r.final_re        <= z_re_r;
      out_data_r.final_im        <= z_im_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Fixed-point escape-time iterator: z = z*z + c until |z| > 2 or the bound.
// ----------------------------------------------------------------------------
// A word is taken when start is high while busy is low; busy then stays high
// until the result is strobed on out_valid for a single cycle, which the
// receiver must take since it cannot stall the block. One shared multiply
// stage sets the pace: each iteration is a multiply step and then an update
// step. The loop ends when z escapes or the count reaches the bound; a bound
// of zero skips the loop. Start may be raised in the cycle the result is
// strobed. Write max_iterations at byte address 0 only while busy is low.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_assert.svh"

module mandelbrot_escape_time
  import mbe_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_t                in_data,
  output logic               out_valid,
  output out_t               out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CNT_W = cnt_w(COUNT_WIDTH);

  logic [CNT_W-1:0] max_iter;
  cmd_t             cmd;
  status_t          sts;

  mbe_regs #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_iter(max_iter)
  );

  mbe_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  mbe_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .max_iter (max_iter),
    .sts      (sts),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  `MBE_ASSERT(a_take_sets_busy, clk, rst_n, (start && !busy) |=> busy, "busy not raised after take")
  `MBE_ASSERT(a_result_when_idle, clk, rst_n, out_valid |-> !busy, "result strobed while busy")
  `MBE_ASSERT(a_single_strobe, clk, rst_n, out_valid |=> !out_valid, "result strobe held over two cycles")
  `MBE_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!busy && !out_valid), "not idle after reset")

endmodule
